@@ rtl/esfb_pkg.sv @@
package esfb_pkg;

  localparam int SCREEN_WIDTH_DEF  = 128;
  localparam int SCREEN_HEIGHT_DEF = 128;

  // 8-bit alpha after nibble expansion
  localparam logic [7:0] ALPHA_FULL = 8'hF0;
  localparam logic [7:0] NIB_LO     = 8'h0F;

  localparam int CFG_IDX_W = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ORIGIN_X     = 3'd0,
    CFG_ORIGIN_Y     = 3'd1,
    CFG_BOX_WIDTH    = 3'd2,
    CFG_BOX_HEIGHT   = 3'd3,
    CFG_STROKE_WIDTH = 3'd4,
    CFG_STROKE_COLOR = 3'd5,
    CFG_FILL_COLOR   = 3'd6
  } cfg_reg_t;

  typedef struct packed {
    logic [8:0]  origin_x;
    logic [8:0]  origin_y;
    logic [7:0]  box_width;
    logic [7:0]  box_height;
    logic [6:0]  stroke_width;
    logic [15:0] stroke_color;
    logic [15:0] fill_color;
  } cfg_t;

  // geometry verdict handed to the blend stage
  typedef struct packed {
    logic        valid;
    logic        hit;
    logic        use_stroke;
    logic [15:0] dest;
  } geom_res_t;

endpackage

@@ rtl/esfb_geom.sv @@
module esfb_geom
  import esfb_pkg::*;
#(
  parameter int SCREEN_WIDTH  = SCREEN_WIDTH_DEF,
  parameter int SCREEN_HEIGHT = SCREEN_HEIGHT_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_vld,
  input  logic [7:0]  col,
  input  logic [7:0]  row,
  input  logic [15:0] dest,
  input  cfg_t        cfg,
  output geom_res_t   res
);

  localparam logic [10:0] SW_L = 11'(SCREEN_WIDTH);
  localparam logic [10:0] SH_L = 11'(SCREEN_HEIGHT);

  // stage 1: box / screen checks, centre offsets, inner radii
  logic [9:0] px, py;
  logic       in_box, on_scr;
  logic [6:0] rx, ry;
  logic [8:0] dx, dy;
  logic [7:0] srx_w, sry_w;
  logic       sen;

  always_comb begin
    px     = {cfg.origin_x[8], cfg.origin_x} + {2'b00, col};
    py     = {cfg.origin_y[8], cfg.origin_y} + {2'b00, row};
    in_box = (col < cfg.box_width) && (row < cfg.box_height);
    on_scr = !px[9] && (11'(px[8:0]) < SW_L) && !py[9] && (11'(py[8:0]) < SH_L);
    rx     = cfg.box_width[7:1];
    ry     = cfg.box_height[7:1];
    dx     = {1'b0, col} - {2'b00, rx};
    dy     = {1'b0, row} - {2'b00, ry};
    srx_w  = {1'b0, rx} - {1'b0, cfg.stroke_width};
    sry_w  = {1'b0, ry} - {1'b0, cfg.stroke_width};
    sen    = (cfg.stroke_width != '0) && !srx_w[7] && (srx_w != '0)
             && !sry_w[7] && (sry_w != '0);
  end

  logic        v1_r, ok1_r, sen1_r;
  logic [6:0]  adx1_r, ady1_r, rx1_r, ry1_r, srx1_r, sry1_r;
  logic [15:0] dest1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else begin
      v1_r <= in_vld;
    end
    ok1_r   <= in_box && on_scr;
    sen1_r  <= sen;
    // offsets stay within 127 whenever the position is in the box
    adx1_r  <= dx[8] ? 7'(-dx) : 7'(dx);
    ady1_r  <= dy[8] ? 7'(-dy) : 7'(dy);
    rx1_r   <= rx;
    ry1_r   <= ry;
    srx1_r  <= srx_w[6:0];
    sry1_r  <= sry_w[6:0];
    dest1_r <= dest;
  end

  // stage 2: squares
  logic        v2_r, ok2_r, sen2_r;
  logic [13:0] dx2_r, dy2_r, rx2_r, ry2_r, srx2_r, sry2_r;
  logic [15:0] dest2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else begin
      v2_r <= v1_r;
    end
    ok2_r   <= ok1_r;
    sen2_r  <= sen1_r;
    dx2_r   <= adx1_r * adx1_r;
    dy2_r   <= ady1_r * ady1_r;
    rx2_r   <= rx1_r * rx1_r;
    ry2_r   <= ry1_r * ry1_r;
    srx2_r  <= srx1_r * srx1_r;
    sry2_r  <= sry1_r * sry1_r;
    dest2_r <= dest1_r;
  end

  // stage 3: cross products of the ellipse inequality
  logic        v3_r, ok3_r, sen3_r;
  logic [27:0] o_x_r, o_y_r, o_r_r, i_x_r, i_y_r, i_r_r;
  logic [15:0] dest3_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else begin
      v3_r <= v2_r;
    end
    ok3_r   <= ok2_r;
    sen3_r  <= sen2_r;
    o_x_r   <= dx2_r * ry2_r;
    o_y_r   <= dy2_r * rx2_r;
    o_r_r   <= rx2_r * ry2_r;
    i_x_r   <= dx2_r * sry2_r;
    i_y_r   <= dy2_r * srx2_r;
    i_r_r   <= srx2_r * sry2_r;
    dest3_r <= dest2_r;
  end

  // stage 4: compares
  logic [28:0] o_sum, i_sum;
  geom_res_t   res_nxt, res_r;

  always_comb begin
    o_sum              = {1'b0, o_x_r} + {1'b0, o_y_r};
    i_sum              = {1'b0, i_x_r} + {1'b0, i_y_r};
    res_nxt.valid      = v3_r;
    res_nxt.hit        = ok3_r && (o_sum <= {1'b0, o_r_r});
    res_nxt.use_stroke = sen3_r && (i_sum > {1'b0, i_r_r});
    res_nxt.dest       = dest3_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_r.valid <= 1'b0;
    end else begin
      res_r.valid <= res_nxt.valid;
    end
    res_r.hit        <= res_nxt.hit;
    res_r.use_stroke <= res_nxt.use_stroke;
    res_r.dest       <= res_nxt.dest;
  end

  assign res = res_r;

endmodule

@@ rtl/esfb_blend.sv @@
module esfb_blend
  import esfb_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  geom_res_t   geo,
  input  cfg_t        cfg,
  output logic        out_valid,
  output logic [15:0] out_pixel,
  output logic        out_we
);

  logic [15:0] fg, bg, mixed, pix_nxt;
  logic [7:0]  fr, fgc, fb, fa, br, bgc, bb, ba, ia, a_ch;
  logic [15:0] r_sum, g_sum, b_sum, a_prod;

  always_comb begin
    fg  = geo.use_stroke ? cfg.stroke_color : cfg.fill_color;
    bg  = geo.dest;
    fr  = fg[7:0] & ~NIB_LO;
    fgc = {fg[3:0], 4'b0000};
    fb  = fg[15:8] & ~NIB_LO;
    fa  = {fg[11:8], 4'b0000};
    br  = bg[7:0] & ~NIB_LO;
    bgc = {bg[3:0], 4'b0000};
    bb  = bg[15:8] & ~NIB_LO;
    ba  = {bg[11:8], 4'b0000};
    ia  = ALPHA_FULL - fa;
    // fa + ia is 0xF0, so each sum stays within 16 bits
    r_sum  = fr * fa + br * ia;
    g_sum  = fgc * fa + bgc * ia;
    b_sum  = fb * fa + bb * ia;
    a_prod = ba * ia;
    a_ch   = fa + a_prod[15:8];
    if (fa == ALPHA_FULL) begin
      mixed = fg;
    end else if (fa == '0) begin
      mixed = bg;
    end else begin
      mixed = {b_sum[15:12], a_ch[7:4], r_sum[15:12], g_sum[15:12]};
    end
    pix_nxt = geo.hit ? mixed : bg;
  end

  logic        vld_r, we_r;
  logic [15:0] pix_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= geo.valid;
    end
    we_r  <= geo.hit;
    pix_r <= pix_nxt;
  end

  assign out_valid = vld_r;
  assign out_pixel = pix_r;
  assign out_we    = we_r;

endmodule

@@ rtl/ellipse_stroke_fill_blend.sv @@
// Ellipse shader with 4444 alpha blend (nibbles B, A, R, G from the top), one pixel per clock.
// Configuration: write register index cfg_index with cfg_data when cfg_valid
// is high; cfg_ready is always high, so every such cycle is a transfer.
// Registers: 0 origin_x, 1 origin_y, 2 box_width, 3 box_height,
// 4 stroke_width, 5 stroke_color, 6 fill_color. Other indices are ignored.
// Write them only while no pixel is in flight.
// Input: raise start with column, row and destination pixel; the transfer
// happens when busy is low. busy is high only while rst_n is low.
// Output: out_valid is high for one cycle with out_pixel_out and
// out_write_enable; there is no back-pressure.
// Each accepted pixel passes through five register stages: offsets, squares,
// cross products, compares, blend. Throughput is one pixel every cycle.
// Reset clears all configuration registers and the pipeline valid bits;
// nothing in flight survives it.
module ellipse_stroke_fill_blend
  import esfb_pkg::*;
#(
  parameter int SCREEN_WIDTH  = SCREEN_WIDTH_DEF,
  parameter int SCREEN_HEIGHT = SCREEN_HEIGHT_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  logic [7:0]           in_col_index,
  input  logic [7:0]           in_row_index,
  input  logic [15:0]          in_dest_pixel,
  output logic                 out_valid,
  output logic [15:0]          out_pixel_out,
  output logic                 out_write_enable,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [15:0]          cfg_data
);

  cfg_t      cfg_r;
  geom_res_t geo;
  logic      in_xfer;

  assign busy      = ~rst_n;
  assign cfg_ready = 1'b1;
  assign in_xfer   = start && !busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_reg_t'(cfg_index))
        CFG_ORIGIN_X:     cfg_r.origin_x     <= cfg_data[8:0];
        CFG_ORIGIN_Y:     cfg_r.origin_y     <= cfg_data[8:0];
        CFG_BOX_WIDTH:    cfg_r.box_width    <= cfg_data[7:0];
        CFG_BOX_HEIGHT:   cfg_r.box_height   <= cfg_data[7:0];
        CFG_STROKE_WIDTH: cfg_r.stroke_width <= cfg_data[6:0];
        CFG_STROKE_COLOR: cfg_r.stroke_color <= cfg_data;
        CFG_FILL_COLOR:   cfg_r.fill_color   <= cfg_data;
        default: ;
      endcase
    end
  end

  esfb_geom #(
    .SCREEN_WIDTH  (SCREEN_WIDTH),
    .SCREEN_HEIGHT (SCREEN_HEIGHT)
  ) u_geom (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_vld (in_xfer),
    .col    (in_col_index),
    .row    (in_row_index),
    .dest   (in_dest_pixel),
    .cfg    (cfg_r),
    .res    (geo)
  );

  esfb_blend u_blend (
    .clk       (clk),
    .rst_n     (rst_n),
    .geo       (geo),
    .cfg       (cfg_r),
    .out_valid (out_valid),
    .out_pixel (out_pixel_out),
    .out_we    (out_write_enable)
  );

  // every result strobe traces back to an accepted pixel
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(in_xfer, 5))
    else $error("result strobe does not match accepted pixel");

  a_no_drop: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |-> ##5 out_valid)
    else $error("accepted pixel produced no result");

  a_box: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_write_enable |->
      $past(in_col_index < cfg_r.box_width && in_row_index < cfg_r.box_height, 5))
    else $error("write enabled outside the bounding box");

  a_passthru: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_write_enable |-> out_pixel_out == $past(in_dest_pixel, 5))
    else $error("unwritten pixel differs from destination");

endmodule

@@ tb/testbench.sv @@
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import esfb_pkg::*;

  localparam int LAT_CYC   = 6;
  localparam int RAND_PIXS = 1100;

  typedef struct {
    logic [7:0]  col;
    logic [7:0]  row;
    logic [15:0] dest;
    bit          hold;  // wait for all in-flight pixels before presenting
  } px_req_t;

  typedef struct {
    logic [15:0] pixel;
    logic        we;
  } px_res_t;

  logic                 clk;
  logic                 rst_n            = 1'b0;
  logic                 start            = 1'b0;
  logic                 busy;
  logic [7:0]           in_col_index     = '0;
  logic [7:0]           in_row_index     = '0;
  logic [15:0]          in_dest_pixel    = '0;
  logic                 out_valid;
  logic [15:0]          out_pixel_out;
  logic                 out_write_enable;
  logic                 cfg_valid        = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index        = '0;
  logic [15:0]          cfg_data         = '0;

  ellipse_stroke_fill_blend uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_col_index     (in_col_index),
    .in_row_index     (in_row_index),
    .in_dest_pixel    (in_dest_pixel),
    .out_valid        (out_valid),
    .out_pixel_out    (out_pixel_out),
    .out_write_enable (out_write_enable),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  // shadow copy of the register file
  logic signed [8:0] sh_org_x  = '0;
  logic signed [8:0] sh_org_y  = '0;
  logic [7:0]        sh_bw     = '0;
  logic [7:0]        sh_bh     = '0;
  logic [6:0]        sh_sw     = '0;
  logic [15:0]       sh_stroke = '0;
  logic [15:0]       sh_fill   = '0;

  px_req_t pend_px_q[$];
  px_res_t want_px_q[$];
  px_req_t cur_px;
  bit      no_gap   = 1'b0;
  int      n_errs   = 0;
  int      n_pixels = 0;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("TEST FAILED");
    $finish;
  end

  task automatic flag_mismatch(string what);
    n_errs++;
    if (n_errs <= 50) $display("ERROR @%0t: %s", $time, what);
  endtask

  function automatic logic [15:0] blend_4444(logic [15:0] fg, logic [15:0] bg);
    int unsigned fr, fgr, fb, fa, br, bgr, bb, ba, ia, rd, gr, bl, al;
    fr  = fg[7:0] & ALPHA_FULL;
    fgr = (fg[7:0] & NIB_LO) << 4;
    fb  = fg[15:8] & ALPHA_FULL;
    fa  = (fg[15:8] & NIB_LO) << 4;
    if (fa == ALPHA_FULL) return fg;
    if (fa == 0) return bg;
    br  = bg[7:0] & ALPHA_FULL;
    bgr = (bg[7:0] & NIB_LO) << 4;
    bb  = bg[15:8] & ALPHA_FULL;
    ba  = (bg[15:8] & NIB_LO) << 4;
    ia  = ALPHA_FULL - fa;
    rd  = (fr * fa + br * ia) >> 8;
    gr  = (fgr * fa + bgr * ia) >> 8;
    bl  = (fb * fa + bb * ia) >> 8;
    al  = fa + ((ba * ia) >> 8);
    return {bl[7:4], al[7:4], rd[7:4], gr[7:4]};
  endfunction

  function automatic px_res_t shade_pixel(px_req_t p);
    px_res_t     r;
    int          c, w, px, py, rx, ry, sx, sy;
    longint      dx2, dy2, rx2, ry2, sx2, sy2;
    logic [15:0] colour;
    r.pixel = p.dest;
    r.we    = 1'b0;
    if (p.col >= sh_bw || p.row >= sh_bh) return r;
    c  = p.col;
    w  = p.row;
    px = sh_org_x + c;
    py = sh_org_y + w;
    if (px < 0 || px >= SCREEN_WIDTH_DEF || py < 0 || py >= SCREEN_HEIGHT_DEF) return r;
    rx  = sh_bw >> 1;
    ry  = sh_bh >> 1;
    rx2 = longint'(rx) * rx;
    ry2 = longint'(ry) * ry;
    dx2 = longint'(c - rx) * (c - rx);
    dy2 = longint'(w - ry) * (w - ry);
    if (dx2 * ry2 + dy2 * rx2 > rx2 * ry2) return r;
    sx = rx - int'(sh_sw);
    sy = ry - int'(sh_sw);
    colour = sh_fill;
    if (sh_sw != 0 && sx > 0 && sy > 0) begin
      sx2 = longint'(sx) * sx;
      sy2 = longint'(sy) * sy;
      if (dx2 * sy2 + dy2 * sx2 > sx2 * sy2) colour = sh_stroke;
    end
    r.pixel = blend_4444(colour, p.dest);
    r.we    = 1'b1;
    return r;
  endfunction

  // driver: one pixel transfer per cycle at most, random gaps
  always @(posedge clk) begin
    bit fired, go;
    fired = start && !busy;
    if (fired) want_px_q.push_back(shade_pixel(cur_px));
    go = start && !fired;
    if (!go && rst_n && pend_px_q.size() != 0) begin
      if (!(pend_px_q[0].hold && want_px_q.size() != 0) &&
          (no_gap || $urandom_range(99) >= 20)) begin
        cur_px        = pend_px_q.pop_front();
        go            = 1'b1;
        in_col_index  <= cur_px.col;
        in_row_index  <= cur_px.row;
        in_dest_pixel <= cur_px.dest;
      end
    end
    start <= go;
  end

  // monitor
  always @(posedge clk) begin
    px_res_t want;
    if (rst_n && out_valid) begin
      if (want_px_q.size() == 0) begin
        flag_mismatch($sformatf("unexpected result pixel=%h we=%b",
                                out_pixel_out, out_write_enable));
      end else begin
        want = want_px_q.pop_front();
        if (out_pixel_out !== want.pixel)
          flag_mismatch($sformatf("pixel_out %h, want %h", out_pixel_out, want.pixel));
        if (out_write_enable !== want.we)
          flag_mismatch($sformatf("write_enable %b, want %b", out_write_enable, want.we));
      end
    end
  end

  // leaves cfg_valid high; caller lowers it after the last write
  task automatic write_reg(cfg_reg_t idx, logic [15:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_ORIGIN_X:     sh_org_x  = val[8:0];
      CFG_ORIGIN_Y:     sh_org_y  = val[8:0];
      CFG_BOX_WIDTH:    sh_bw     = val[7:0];
      CFG_BOX_HEIGHT:   sh_bh     = val[7:0];
      CFG_STROKE_WIDTH: sh_sw     = val[6:0];
      CFG_STROKE_COLOR: sh_stroke = val;
      CFG_FILL_COLOR:   sh_fill   = val;
      default: ;
    endcase
  endtask

  task automatic set_cfg(int ox, int oy, int bw, int bh, int sw,
                         logic [15:0] sc, logic [15:0] fc);
    write_reg(CFG_ORIGIN_X, 16'(ox));
    write_reg(CFG_ORIGIN_Y, 16'(oy));
    write_reg(CFG_BOX_WIDTH, 16'(bw));
    write_reg(CFG_BOX_HEIGHT, 16'(bh));
    write_reg(CFG_STROKE_WIDTH, 16'(sw));
    write_reg(CFG_STROKE_COLOR, sc);
    write_reg(CFG_FILL_COLOR, fc);
    cfg_valid <= 1'b0;
  endtask

  task automatic add_px(int col, int row, logic [15:0] dest, bit hold);
    px_req_t p;
    p.col  = col[7:0];
    p.row  = row[7:0];
    p.dest = dest;
    p.hold = hold;
    pend_px_q.push_back(p);
    n_pixels++;
  endtask

  // pipeline must be empty before the registers change
  task automatic wait_idle();
    do @(posedge clk);
    while (pend_px_q.size() != 0 || start || want_px_q.size() != 0);
    repeat (LAT_CYC) @(posedge clk);
  endtask

  function automatic logic [15:0] rand_colour();
    logic [15:0] c;
    c = 16'($urandom);
    case ($urandom_range(2))
      0: c[11:8] = 4'h0;
      1: c[11:8] = 4'hF;
      default: ;
    endcase
    return c;
  endfunction

  initial begin
    int ox, oy, bw, bh, sw, cnt, k;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // registers at reset: empty box
    add_px(0, 0, 16'h1234, 0);
    add_px(255, 255, 16'hFFFF, 0);
    wait_idle();

    // 9x9 box, radii 4, one-pixel stroke, opaque stroke over part-alpha fill
    set_cfg(0, 0, 9, 9, 1, 16'h5F3C, 16'hA796);
    add_px(4, 4, 16'h0000, 0);
    add_px(0, 4, 16'hFFFF, 0);
    add_px(0, 0, 16'h8421, 0);
    add_px(8, 4, 16'h7E5A, 0);
    add_px(9, 4, 16'h1111, 0);
    add_px(4, 9, 16'h2222, 0);
    add_px(3, 5, 16'hC3A5, 0);
    wait_idle();

    // inner radius not positive, transparent fill
    set_cfg(0, 0, 9, 9, 127, 16'h5F3C, 16'h30C5);
    add_px(4, 4, 16'hBEEF, 0);
    add_px(1, 4, 16'h0F0F, 0);
    wait_idle();

    set_cfg(-256, 0, 9, 9, 1, 16'h5F3C, 16'hA796);
    add_px(4, 4, 16'h5555, 0);
    wait_idle();
    set_cfg(255, -256, 9, 9, 1, 16'h5F3C, 16'hA796);
    add_px(4, 4, 16'hAAAA, 0);
    wait_idle();

    // right and bottom screen edges
    set_cfg(119, 119, 9, 9, 2, 16'h5F3C, 16'hA796);
    add_px(8, 4, 16'h1357, 0);
    add_px(4, 8, 16'h2468, 0);
    wait_idle();
    set_cfg(120, 0, 9, 9, 2, 16'h5F3C, 16'hA796);
    add_px(8, 4, 16'h9BDF, 0);
    add_px(7, 4, 16'hECA8, 0);
    wait_idle();

    // largest box
    set_cfg(-64, -64, 255, 255, 127, 16'h0F00, 16'hFFFF);
    add_px(127, 127, 16'h0000, 0);
    add_px(191, 127, 16'h7777, 0);
    wait_idle();
    set_cfg(-64, -64, 255, 255, 1, 16'h4FE2, 16'h0000);
    add_px(64, 127, 16'h3C3C, 0);
    add_px(127, 1, 16'hC3C3, 0);
    add_px(127, 0, 16'h6996, 0);
    add_px(254, 127, 16'h9669, 0);
    wait_idle();

    n_pixels = 0;
    for (int ph = 0; n_pixels < RAND_PIXS; ph++) begin
      ox = ($urandom_range(9) < 7) ? int'($urandom_range(130)) - 30
                                   : int'($urandom_range(511)) - 256;
      oy = ($urandom_range(9) < 7) ? int'($urandom_range(130)) - 30
                                   : int'($urandom_range(511)) - 256;
      case ($urandom_range(9))
        0: begin
          bw = ($urandom_range(1) == 0) ? 255 : $urandom_range(1);
          bh = ($urandom_range(1) == 0) ? 255 : $urandom_range(1);
        end
        1, 2: begin
          bw = $urandom_range(255);
          bh = $urandom_range(255);
        end
        default: begin
          bw = $urandom_range(40, 1);
          bh = $urandom_range(40, 1);
        end
      endcase
      case ($urandom_range(4))
        0, 1: sw = 0;
        2, 3: sw = $urandom_range(10, 1);
        default: sw = $urandom_range(127);
      endcase
      cnt = $urandom_range(70, 40);
      // the gap-free phase always takes the full random batch
      if (ph != 3 && $urandom_range(3) == 0) begin
        // raster scan of a small box
        bw = $urandom_range(12, 1);
        bh = $urandom_range(12, 1);
        set_cfg(ox, oy, bw, bh, sw, rand_colour(), rand_colour());
        no_gap = (ph == 3);
        k = 0;
        for (int j = 0; j < bh && k < cnt; j++)
          for (int i = 0; i < bw && k < cnt; i++) begin
            add_px(i, j, 16'($urandom), $urandom_range(99) < 2);
            k++;
          end
      end else begin
        set_cfg(ox, oy, bw, bh, sw, rand_colour(), rand_colour());
        no_gap = (ph == 3);
        for (int i = 0; i < cnt; i++) begin
          if (bw != 0 && bh != 0 && $urandom_range(99) < 85)
            add_px($urandom_range(bw - 1), $urandom_range(bh - 1), 16'($urandom),
                   $urandom_range(99) < 2);
          else
            add_px($urandom_range(255), $urandom_range(255), 16'($urandom),
                   $urandom_range(99) < 2);
        end
      end
      wait_idle();
      no_gap = 1'b0;
    end

    wait_idle();
    if (want_px_q.size() != 0)
      flag_mismatch($sformatf("%0d results never arrived", want_px_q.size()));
    if (n_errs == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
